>>> hdl/hkbs_pkg.sv
package hkbs_pkg;

    localparam int KEY_W       = 64;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 13;
    localparam int MUL_W       = 32;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;

    localparam logic [KEY_W-1:0] MIX_MUL = 64'h2127_599b_f432_5c37;
    localparam int MIX_SHIFT_A = 23;
    localparam int MIX_SHIFT_B = 47;

    localparam int FOLD_BITS   = 8;
    localparam int FOLD_CHUNKS = KEY_W / FOLD_BITS;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef struct packed {
        logic success;
        logic bucket_full;
        logic grow;
        logic shrink;
    } tbl_res_t;

endpackage

>>> hdl/hkbs_hash.sv
module hkbs_hash
    import hkbs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    localparam int IDX_W = $clog2(BUCKETS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [IDX_W-1:0] bucket
);

    localparam int WGT_W = 16;
    localparam int SUM_W = FOLD_BITS + WGT_W + $clog2(FOLD_CHUNKS);
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(BUCKETS);
    localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / BUCKETS);

    // weight of each key byte modulo BUCKETS
    function automatic logic [FOLD_CHUNKS*WGT_W-1:0] fold_weights();
        logic [FOLD_CHUNKS*WGT_W-1:0] w;
        logic [63:0]                  r;
        w = '0;
        r = 64'(1 % BUCKETS);
        for (int i = 0; i < FOLD_CHUNKS; i++)
        begin
            w[i*WGT_W +: WGT_W] = WGT_W'(r);
            r = (r << FOLD_BITS) % 64'(BUCKETS);
        end
        return w;
    endfunction

    localparam logic [FOLD_CHUNKS*WGT_W-1:0] WEIGHTS = fold_weights();

    localparam logic [3:0] H_IDLE = 4'd0;
    localparam logic [3:0] H_MUL0 = 4'd1;
    localparam logic [3:0] H_MUL1 = 4'd2;
    localparam logic [3:0] H_MUL2 = 4'd3;
    localparam logic [3:0] H_SUM  = 4'd4;
    localparam logic [3:0] H_FOLD = 4'd5;
    localparam logic [3:0] H_QUOT = 4'd6;
    localparam logic [3:0] H_REM  = 4'd7;
    localparam logic [3:0] H_FIX  = 4'd8;

    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    logic                 done_reg;
    logic                 done_next;

    logic [KEY_W-1:0]     x_reg;
    logic [KEY_W-1:0]     x_next;
    logic [2*MUL_W-1:0]   pll_reg;
    logic [MUL_W-1:0]     plh_reg;
    logic [MUL_W-1:0]     phl_reg;
    logic [SUM_W-1:0]     v_reg;
    logic [SUM_W-1:0]     v_next;
    logic [SUM_W-1:0]     q_reg;
    logic [IDX_W-1:0]     bucket_reg;

    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [2*MUL_W-1:0]   mul_p;

    logic [MUL_W-1:0]     sum_hi;
    logic [KEY_W-1:0]     mixed;

    logic [SUM_W-1:0]     fold_lvl [FOLD_CHUNKS];
    logic [SUM_W-1:0]     fold_sum;
    logic [2*SUM_W-1:0]   quot_prod;
    logic [SUM_W-1:0]     back_prod;
    logic [SUM_W-1:0]     fixed;

    always_comb
    begin
        unique case (state_reg)
            H_MUL0:
            begin
                mul_a = x_reg[MUL_W-1:0];
                mul_b = MIX_MUL[MUL_W-1:0];
            end
            H_MUL1:
            begin
                mul_a = x_reg[MUL_W-1:0];
                mul_b = MIX_MUL[2*MUL_W-1:MUL_W];
            end
            default:
            begin
                mul_a = x_reg[2*MUL_W-1:MUL_W];
                mul_b = MIX_MUL[MUL_W-1:0];
            end
        endcase
    end

    assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

    assign sum_hi = pll_reg[2*MUL_W-1:MUL_W] + plh_reg + phl_reg;
    assign mixed  = {sum_hi, pll_reg[MUL_W-1:0]};

    // fold the key bytes by their weights, summed as a tree
    always_comb
    begin
        for (int i = 0; i < FOLD_CHUNKS; i++)
        begin
            fold_lvl[i] = SUM_W'(x_reg[i*FOLD_BITS +: FOLD_BITS])
                        * SUM_W'(WEIGHTS[i*WGT_W +: WGT_W]);
        end
        for (int span = 1; span < FOLD_CHUNKS; span = span * 2)
        begin
            for (int i = 0; i + span < FOLD_CHUNKS; i = i + 2 * span)
            begin
                fold_lvl[i] = fold_lvl[i] + fold_lvl[i + span];
            end
        end
        fold_sum = fold_lvl[0];
    end

    assign quot_prod = (2*SUM_W)'(v_reg) * (2*SUM_W)'(RECIP);
    assign back_prod = q_reg * DIVISOR;
    assign fixed     = (v_reg >= DIVISOR) ? v_reg - DIVISOR : v_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        v_next     = v_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (go)
                begin
                    x_next     = key ^ (key >> MIX_SHIFT_A);
                    state_next = H_MUL0;
                end
            end
            H_MUL0:
            begin
                state_next = H_MUL1;
            end
            H_MUL1:
            begin
                state_next = H_MUL2;
            end
            H_MUL2:
            begin
                state_next = H_SUM;
            end
            H_SUM:
            begin
                x_next     = mixed ^ (mixed >> MIX_SHIFT_B);
                state_next = H_FOLD;
            end
            H_FOLD:
            begin
                v_next     = fold_sum;
                state_next = H_QUOT;
            end
            H_QUOT:
            begin
                state_next = H_REM;
            end
            H_REM:
            begin
                v_next     = v_reg - back_prod;
                state_next = H_FIX;
            end
            H_FIX:
            begin
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        v_reg <= v_next;
        if (state_reg == H_MUL0)
        begin
            pll_reg <= mul_p;
        end
        if (state_reg == H_MUL1)
        begin
            plh_reg <= mul_p[MUL_W-1:0];
        end
        if (state_reg == H_MUL2)
        begin
            phl_reg <= mul_p[MUL_W-1:0];
        end
        if (state_reg == H_QUOT)
        begin
            q_reg <= quot_prod[2*SUM_W-1:SUM_W];
        end
        if (done_next)
        begin
            bucket_reg <= fixed[IDX_W-1:0];
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

>>> hdl/hkbs_table.sv
module hkbs_table
    import hkbs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS,
    localparam int IDX_W = $clog2(BUCKETS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [KIND_W-1:0] kind,
    input  logic [KEY_W-1:0]  key,
    input  logic [IDX_W-1:0]  bucket,
    output logic              clearing,
    output logic              done,
    output tbl_res_t          res
);

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BUCKETS - 1);

    logic [WAYS-1:0][KEY_W-1:0] key_mem [BUCKETS];
    logic [WAYS-1:0]            vld_mem [BUCKETS];

    logic                       clr_reg;
    logic [IDX_W-1:0]           clr_idx_reg;
    logic                       eval_reg;

    logic [WAYS-1:0][KEY_W-1:0] rd_keys_reg;
    logic [WAYS-1:0]            rd_vld_reg;

    logic [WAYS-1:0]            hit;
    logic [WAYS-1:0]            free;
    logic [WAYS-1:0]            pick;
    logic [WAYS-1:0]            vld_next;
    logic [WAYS-1:0][KEY_W-1:0] keys_next;
    logic                       wr_vld;
    logic                       wr_key;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w]       = rd_vld_reg[w] && (rd_keys_reg[w] == key);
            keys_next[w] = pick[w] ? key : rd_keys_reg[w];
        end
    end

    assign free = ~rd_vld_reg;
    assign pick = free & (~free + 1'b1);

    always_comb
    begin
        res      = '0;
        vld_next = rd_vld_reg;
        wr_vld   = 1'b0;
        wr_key   = 1'b0;
        unique case (kind)
            KIND_LOOKUP:
            begin
                res.success = |hit;
            end
            KIND_INSERT:
            begin
                if (!(|hit))
                begin
                    if (|free)
                    begin
                        res.success = 1'b1;
                        res.grow    = 1'b1;
                        vld_next    = rd_vld_reg | pick;
                        wr_vld      = eval_reg;
                        wr_key      = eval_reg;
                    end
                    else
                    begin
                        res.bucket_full = 1'b1;
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (|hit)
                begin
                    res.success = 1'b1;
                    res.shrink  = 1'b1;
                    vld_next    = rd_vld_reg & ~hit;
                    wr_vld      = eval_reg;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            eval_reg    <= 1'b0;
        end
        else
        begin
            eval_reg <= go && !clr_reg;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ROW)
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            vld_mem[clr_idx_reg] <= '0;
        end
        else if (wr_vld)
        begin
            vld_mem[bucket] <= vld_next;
        end
        if (wr_key)
        begin
            key_mem[bucket] <= keys_next;
        end
        if (go)
        begin
            rd_vld_reg  <= vld_mem[bucket];
            rd_keys_reg <= key_mem[bucket];
        end
    end

    assign clearing = clr_reg;
    assign done     = eval_reg;

endmodule

>>> hdl/hashed_key_blocklist_set_unit.sv
// Hashed key set: lookup, insert or remove of one 64-bit key per command.
// Input: drive kind and card_number with start high; the command transfers
// at the rising edge where start is high and busy is low. Hold nothing after
// that edge: the key is captured.
// Output: done is high for exactly one cycle with success, bucket_full and
// live_count valid; the receiver cannot stall, so the result is taken then.
// Commands do not overlap: busy is high from the accepting edge until the
// done cycle, in which busy is low again and the next command can transfer.
// The key goes through the bucket hash: three passes through one shared
// 32x32 multiplier plus a sum step, then the steps that reduce the mix
// modulo BUCKETS (byte fold, reciprocal multiply, back multiply, final
// subtract), then a bucket-row read and an evaluate/write-back step on
// the table memory.
// Reset: the live count goes to zero and a clearing pass walks the table,
// one bucket row per cycle, over all BUCKETS rows; busy stays high meanwhile.
// A full bucket refuses inserts with bucket_full set; the table never grows.
module hashed_key_blocklist_set_unit
    import hkbs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   card_number,
    output logic               done,
    output logic               success,
    output logic               bucket_full,
    output logic [COUNT_W-1:0] live_count
);

    localparam int IDX_W = $clog2(BUCKETS);

    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               success_reg;
    logic               full_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [KEY_W-1:0]   key_reg;

    logic               accept;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_bucket;
    logic               tbl_clearing;
    logic               tbl_done;
    tbl_res_t           tbl_res;

    assign busy   = busy_reg || tbl_clearing;
    assign accept = start && !busy;

    hkbs_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (accept),
        .key    (card_number),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    hkbs_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (hash_done),
        .kind     (kind_reg),
        .key      (key_reg),
        .bucket   (hash_bucket),
        .clearing (tbl_clearing),
        .done     (tbl_done),
        .res      (tbl_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= tbl_done;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tbl_done)
            begin
                busy_reg <= 1'b0;
            end
            if (tbl_done && tbl_res.grow)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (tbl_done && tbl_res.shrink)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= card_number;
        end
        if (tbl_done)
        begin
            success_reg <= tbl_res.success;
            full_reg    <= tbl_res.bucket_full;
        end
    end

    assign done        = done_reg;
    assign success     = success_reg;
    assign bucket_full = full_reg;
    assign live_count  = count_reg;

endmodule

>>> sim/hkbs_result_checker.sv
module hkbs_result_checker
    import hkbs_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [KEY_W-1:0]   card_number,
    input  logic               done,
    input  logic               success,
    input  logic               bucket_full,
    input  logic [COUNT_W-1:0] live_count,
    output int                 mismatches,
    output int                 pending
);

    localparam int SLOTS = BUCKETS * WAYS;

    typedef struct packed {
        logic               success;
        logic               bucket_full;
        logic [COUNT_W-1:0] live_count;
    } set_result_t;

    logic [KEY_W-1:0]   held_keys [SLOTS];
    logic               held_valid[SLOTS];
    logic [COUNT_W-1:0] held_total;
    set_result_t        expected_results[$];

    function automatic int bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] x;
        x = key ^ (key >> MIX_SHIFT_A);
        x = x * MIX_MUL;
        x = x ^ (x >> MIX_SHIFT_B);
        return int'(x % BUCKETS);
    endfunction

    task automatic apply_command(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] key);
        int          base;
        int          w;
        int          hit;
        int          free_slot;
        set_result_t r;
        base      = bucket_of(key) * WAYS;
        hit       = -1;
        free_slot = -1;
        for (w = 0; w < WAYS; w++) begin
            if (held_valid[base + w] && held_keys[base + w] == key && hit < 0)
                hit = base + w;
            if (!held_valid[base + w] && free_slot < 0)
                free_slot = base + w;
        end
        r.success     = 1'b0;
        r.bucket_full = 1'b0;
        case (k)
            KIND_LOOKUP: r.success = (hit >= 0);
            KIND_INSERT:
            begin
                if (hit < 0) begin
                    if (free_slot >= 0) begin
                        held_valid[free_slot] = 1'b1;
                        held_keys[free_slot]  = key;
                        held_total            = held_total + 1'b1;
                        r.success             = 1'b1;
                    end
                    else begin
                        r.bucket_full = 1'b1;
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (hit >= 0) begin
                    held_valid[hit] = 1'b0;
                    held_total      = held_total - 1'b1;
                    r.success       = 1'b1;
                end
            end
            default: ;
        endcase
        r.live_count = held_total;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        int          s;
        if (!rst_n) begin
            for (s = 0; s < SLOTS; s++) begin
                held_valid[s] = 1'b0;
                held_keys[s]  = '0;
            end
            held_total = '0;
            mismatches = 0;
            expected_results.delete();
        end
        else begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (success !== want.success) begin
                        $error("success: expected %0b, actual %0b", want.success, success);
                        mismatches++;
                    end
                    if (bucket_full !== want.bucket_full) begin
                        $error("bucket_full: expected %0b, actual %0b",
                               want.bucket_full, bucket_full);
                        mismatches++;
                    end
                    if (live_count !== want.live_count) begin
                        $error("live_count: expected %0d, actual %0d",
                               want.live_count, live_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                apply_command(kind, card_number);
        end
        pending = expected_results.size();
    end

endmodule

>>> sim/tb_hashed_key_blocklist_set_unit.sv
module tb_hashed_key_blocklist_set_unit;
    import hkbs_pkg::*;

    localparam int BUCKETS      = DEF_BUCKETS;
    localparam int WAYS         = DEF_WAYS;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int CLASH_GROUPS = 16;
    localparam int CLASH_DEPTH  = WAYS + 2;
    localparam int LOOSE_KEYS   = 32;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic [KIND_W-1:0]  kind        = KIND_LOOKUP;
    logic [KEY_W-1:0]   card_number = '0;
    logic               busy;
    logic               done;
    logic               success;
    logic               bucket_full;
    logic [COUNT_W-1:0] live_count;
    int                 mismatches;
    int                 pending;
    int                 cycles      = 0;
    int                 burst_left  = 0;

    logic [KEY_W-1:0]   clash_keys[CLASH_GROUPS][CLASH_DEPTH];
    logic [KEY_W-1:0]   loose_keys[LOOSE_KEYS];

    hashed_key_blocklist_set_unit #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .card_number (card_number),
        .done        (done),
        .success     (success),
        .bucket_full (bucket_full),
        .live_count  (live_count)
    );

    hkbs_result_checker #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .card_number (card_number),
        .done        (done),
        .success     (success),
        .bucket_full (bucket_full),
        .live_count  (live_count),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int target_bucket(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] x;
        x = key ^ (key >> MIX_SHIFT_A);
        x = x * MIX_MUL;
        x = x ^ (x >> MIX_SHIFT_B);
        return int'(x % BUCKETS);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // hold start high across back-to-back transfers; idle only between bursts
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] key);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start       <= 1'b1;
        kind        <= k;
        card_number <= key;
        do @(posedge clk); while (busy);
    endtask

    initial
    begin
        int               g;
        int               d;
        int               b;
        int               counted;
        int               pick;
        int               settle;
        logic [KIND_W-1:0] k;
        logic [KEY_W-1:0]  key;

        // build groups of keys that share one bucket
        for (g = 0; g < CLASH_GROUPS; g++) begin
            b = $urandom_range(0, BUCKETS - 1);
            d = 0;
            while (d < CLASH_DEPTH) begin
                key = random_key();
                if (target_bucket(key) == b) begin
                    clash_keys[g][d] = key;
                    d++;
                end
            end
        end
        for (g = 0; g < LOOSE_KEYS; g++)
            loose_keys[g] = random_key();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(KIND_LOOKUP, '0);
        send_cmd(KIND_INSERT, '0);
        send_cmd(KIND_INSERT, '0);
        send_cmd(KIND_LOOKUP, '0);
        send_cmd(KIND_INSERT, '1);
        send_cmd(KIND_LOOKUP, '1);
        send_cmd(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(KIND_INSERT, 64'h5555_5555_5555_5555);
        send_cmd(KIND_REMOVE, 64'h0123_4567_89AB_CDEF);
        send_cmd(KIND_REMOVE, '0);
        send_cmd(KIND_REMOVE, '0);
        send_cmd(KIND_UNUSED, '1);
        for (d = 0; d <= WAYS; d++)
            send_cmd(KIND_INSERT, clash_keys[0][d]);
        send_cmd(KIND_REMOVE, clash_keys[0][1]);
        send_cmd(KIND_INSERT, clash_keys[0][WAYS]);
        send_cmd(KIND_LOOKUP, clash_keys[0][WAYS]);
        send_cmd(KIND_LOOKUP, clash_keys[0][1]);
        send_cmd(KIND_INSERT, clash_keys[0][WAYS + 1]);
        send_cmd(KIND_INSERT, clash_keys[0][WAYS]);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                k = KIND_UNUSED;
            else if (pick < 47)
                k = KIND_INSERT;
            else if (pick < 72)
                k = KIND_REMOVE;
            else
                k = KIND_LOOKUP;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                key = clash_keys[$urandom_range(0, CLASH_GROUPS - 1)]
                                [$urandom_range(0, CLASH_DEPTH - 1)];
            end
            else if (pick < 85) begin
                key = loose_keys[$urandom_range(0, LOOSE_KEYS - 1)];
            end
            else begin
                key = random_key();
                if (k == KIND_INSERT && $urandom_range(0, 1) == 1)
                    loose_keys[$urandom_range(0, LOOSE_KEYS - 1)] = key;
            end
            send_cmd(k, key);
            if (k != KIND_UNUSED)
                counted++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (settle = 0; settle < 40; settle++)
            @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> hashed_key_blocklist_set_unit.f
hdl/hkbs_pkg.sv
hdl/hkbs_hash.sv
hdl/hkbs_table.sv
hdl/hashed_key_blocklist_set_unit.sv
sim/hkbs_result_checker.sv
sim/tb_hashed_key_blocklist_set_unit.sv
